// ===== rtl/difficulty_retarget_core_assert.svh =====
// ----------------------------------------------------------------------------
// Difficulty retarget assertion macros
// Concurrent assertion macros shared by the difficulty retarget RTL.
// ----------------------------------------------------------------------------
`ifndef DIFFICULTY_RETARGET_CORE_ASSERT_SVH
`define DIFFICULTY_RETARGET_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("difficulty retarget assertion failed");
`define DRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("difficulty retarget assertion failed");
`else
`define DRT_ASSERT_IMP(lbl, ante, cons)
`define DRT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// Difficulty retarget package
// Pipeline stage numbering, configuration register codes and item types.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int TARGET_WIDTH = 256;
  localparam int DIV_STEP_BITS = 8;
  localparam int NUM_BITS = 104;
  localparam int DIV_STAGES = NUM_BITS / DIV_STEP_BITS;

  localparam int ST_IN = 0;
  localparam int ST_DEC = 1;
  localparam int ST_DIV100 = 2;
  localparam int ST_CLAMP = 3;
  localparam int ST_MUL = 4;
  localparam int ST_MASK = 5;
  localparam int ST_DIV0 = 6;
  localparam int ST_CMP = 7;
  localparam int ST_SEL = ST_DIV0 + DIV_STAGES;
  localparam int ST_ENC = ST_SEL + 1;
  localparam int NUM_STAGES = ST_ENC + 1;

  localparam logic [30:0] RECIP_100 = 31'h51EB851F;

  localparam logic [21:0] IDEAL_RST = 22'd1209600;
  localparam logic [9:0] MIN_RST = 10'd25;
  localparam logic [9:0] MAX_RST = 10'd400;
  localparam logic [31:0] LIMIT_RST = 32'h1D00FFFF;

  typedef enum logic [1:0] {
    REG_IDEAL = 2'd0,
    REG_MIN   = 2'd1,
    REG_MAX   = 2'd2,
    REG_LIMIT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [21:0] ideal;
    logic [9:0]  minp;
    logic [9:0]  maxp;
    logic [31:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [22:0] mt;
    logic [4:0]  kb;
    logic        neg;
    logic        ovf;
  } dec_t;

  typedef struct packed {
    logic [31:0]  prev;
    logic [63:0]  t_end;
    logic [63:0]  t_start;
    logic [63:0]  diff;
    logic [31:0]  pmin;
    logic [31:0]  pmax;
    logic [25:0]  mn;
    logic [25:0]  mx;
    logic [22:0]  mt;
    logic [4:0]   kb;
    logic         fb;
    logic [22:0]  lw;
    logic [4:0]   lkb;
    logic [25:0]  mul;
    logic [48:0]  p;
    logic [44:0]  m;
    logic [48:0]  w;
    logic [279:0] x;
    logic [279:0] y;
    logic         capped;
    logic [21:0]  rem;
    logic [103:0] nq;
    logic [255:0] v;
    logic [31:0]  nc;
  } item_t;

endpackage

// ===== rtl/difficulty_retarget_core.sv =====
// ----------------------------------------------------------------------------
// Difficulty retarget core
// Computes the next compact proof-of-work target from the previous one and
// the timestamps that bound an adjustment window.
// ----------------------------------------------------------------------------
// Input items arrive on the in_valid_i/in_ready_o channel and results leave
// on the out_valid_o/out_ready_i channel; each transfer moves one item.
// Configuration registers are written through the cfg_valid_i channel, which
// is always ready; they should only change while no item is in flight.
// The core is a 21-stage pipeline that can take one item every cycle while
// the receiver is not stalling. The 104-bit quotient comes from a restoring
// divider spread over 13 stages at 8 bits per stage, which sets the depth.
// Reset clears all stage valid bits and loads the configuration defaults.
// When the receiver stalls, the output holds and stages behind it close
// their gaps; once every stage is full, in_ready_o drops.
// ----------------------------------------------------------------------------
module difficulty_retarget_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] prev_compact_i,
  input  logic [63:0] window_end_time_i,
  input  logic [63:0] window_start_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_compact_o,
  output logic        fell_back_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import drt_pkg::*;

  `include "difficulty_retarget_core_assert.svh"

  cfg_t  cfg_q;
  logic  valid_q [NUM_STAGES];
  item_t data_q [NUM_STAGES];
  item_t data_d [NUM_STAGES];
  logic  en [NUM_STAGES];

  function automatic dec_t decode_compact(input logic [31:0] bits);
    dec_t r;
    logic [7:0] size;
    logic [22:0] ws;
    logic [7:0] kbig;
    size = bits[31:24];
    r = '0;
    kbig = '0;
    if (size <= 8'd3) begin
      ws = bits[22:0] >> {2'd3 - size[1:0], 3'b000};
      r.mt = ws;
    end else begin
      ws = bits[22:0];
      kbig = size - 8'd3;
      r.kb = kbig[4:0];
      r.mt = {(kbig < 8'd30) ? ws[22:16] : 7'd0,
              (kbig < 8'd31) ? ws[15:8] : 8'd0,
              (kbig < 8'd32) ? ws[7:0] : 8'd0};
    end
    r.neg = (ws != '0) && bits[23];
    r.ovf = (ws != '0) && ((size > 8'd34) || ((ws > 23'hff) && (size > 8'd33)) ||
                           ((ws > 23'hffff) && (size > 8'd32)));
    return r;
  endfunction

  function automatic logic [31:0] encode_compact(input logic [255:0] v);
    logic [7:0] size;
    logic [23:0] comp;
    size = '0;
    for (int i = 0; i < TARGET_WIDTH / 8; i++) begin
      if (v[8*i +: 8] != '0) begin
        size = 8'(i + 1);
      end
    end
    if (size <= 8'd3) begin
      comp = v[23:0] << {2'd3 - size[1:0], 3'b000};
    end else begin
      comp = 24'(v >> {size - 8'd3, 3'b000});
    end
    if (comp[23]) begin
      comp = comp >> 8;
      size = size + 8'd1;
    end
    return {size, comp};
  endfunction

  function automatic item_t stage_fn(input int s, input item_t a, input cfg_t c);
    item_t r;
    dec_t dp;
    dec_t dl;
    logic [63:0] c1;
    logic [62:0] pr;
    logic [8:0] sh;
    logic [22:0] r2;
    logic [7:0] esh;
    r = a;
    if (s == ST_DEC) begin
      dp = decode_compact(a.prev);
      dl = decode_compact(c.limit);
      r.mt = dp.mt;
      r.kb = dp.kb;
      r.fb = dp.neg || dp.ovf || (dp.mt == '0);
      r.lw = dl.mt;
      r.lkb = dl.kb;
      r.diff = a.t_end - a.t_start;
      r.pmin = 32'(c.ideal) * 32'(c.minp);
      r.pmax = 32'(c.ideal) * 32'(c.maxp);
    end
    if (s == ST_DIV100) begin
      pr = 63'(a.pmin) * 63'(RECIP_100);
      r.mn = pr[62:37];
      pr = 63'(a.pmax) * 63'(RECIP_100);
      r.mx = pr[62:37];
    end
    if (s == ST_CLAMP) begin
      c1 = (a.diff[63] || (a.diff < 64'(a.mn))) ? 64'(a.mn) : a.diff;
      if (c1 > 64'(a.mx)) begin
        c1 = 64'(a.mx);
      end
      r.mul = c1[25:0];
    end
    if (s == ST_MUL) begin
      r.p = 49'(a.mt) * 49'(a.mul);
      r.m = 45'(a.lw) * 45'(c.ideal);
    end
    if (s == ST_MASK) begin
      sh = 9'd256 - 9'({a.kb, 3'b000});
      r.w = (sh < 9'd49) ? (a.p & ((49'd1 << sh) - 49'd1)) : a.p;
      r.nq = {7'd0, r.w, 48'd0};
      r.rem = '0;
    end
    if (s >= ST_DIV0 && s < ST_SEL) begin
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
        r2 = {r.rem, r.nq[NUM_BITS-1]};
        r.nq = r.nq << 1;
        if (r2 >= {1'b0, c.ideal}) begin
          r2 = r2 - {1'b0, c.ideal};
          r.nq[0] = 1'b1;
        end
        r.rem = r2[21:0];
      end
    end
    if (s == ST_DIV0) begin
      r.x = 280'(a.w) << {a.kb, 3'b000};
      r.y = (280'(a.m) << {a.lkb, 3'b000}) + 280'(c.ideal);
    end
    if (s == ST_CMP) begin
      r.capped = (a.x >= a.y);
    end
    if (s == ST_SEL) begin
      esh = {a.kb, 3'b000};
      if (a.capped) begin
        r.v = 256'(a.lw) << {a.lkb, 3'b000};
      end else if (esh >= 8'd48) begin
        r.v = 256'(a.nq) << (esh - 8'd48);
      end else begin
        r.v = 256'(a.nq >> (8'd48 - esh));
      end
    end
    if (s == ST_ENC) begin
      r.nc = a.fb ? c.limit : encode_compact(a.v);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ideal <= IDEAL_RST;
      cfg_q.minp <= MIN_RST;
      cfg_q.maxp <= MAX_RST;
      cfg_q.limit <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IDEAL: cfg_q.ideal <= cfg_data_i[21:0];
        REG_MIN:   cfg_q.minp <= cfg_data_i[9:0];
        REG_MAX:   cfg_q.maxp <= cfg_data_i[9:0];
        REG_LIMIT: cfg_q.limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_comb begin
    data_d[ST_IN] = '0;
    data_d[ST_IN].prev = prev_compact_i;
    data_d[ST_IN].t_end = window_end_time_i;
    data_d[ST_IN].t_start = window_start_time_i;
    for (int s = 1; s < NUM_STAGES; s++) begin
      data_d[s] = stage_fn(s, data_q[s-1], cfg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      if (en[ST_IN]) begin
        valid_q[ST_IN] <= in_valid_i;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (en[s]) begin
        data_q[s] <= data_d[s];
      end
    end
  end

  assign in_ready_o = en[ST_IN];
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign next_compact_o = data_q[NUM_STAGES-1].nc;
  assign fell_back_o = data_q[NUM_STAGES-1].fb;

  `DRT_ASSERT_IMP(a_ready_low_full, !in_ready_o, valid_q[ST_IN] && out_valid_o)
  `DRT_ASSERT_IMP(a_size_range, out_valid_o && !fell_back_o, next_compact_o[31:24] <= 8'd33)
  `DRT_ASSERT_IMP(a_sign_clear, out_valid_o && !fell_back_o, !next_compact_o[23])

endmodule
